[rtl/pee_pkg.sv]
// Shared types and constants for the postfix expression evaluator.
package pee_pkg;

    // Operation classes handed from the front end to the execute unit
    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_PUSH = 3'd1;
    localparam logic [2:0] OP_ADD  = 3'd2;
    localparam logic [2:0] OP_SUB  = 3'd3;
    localparam logic [2:0] OP_MUL  = 3'd4;
    localparam logic [2:0] OP_DIV  = 3'd5;
    localparam logic [2:0] OP_POW  = 3'd6;
    localparam logic [2:0] OP_END  = 3'd7;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [1:0] ST_LEFTOVER = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [31:0] DEC_BASE = 32'd10;

    // One queued command: operation class and its value
    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] value;
    } t_cmd;

endpackage

[rtl/pee_front.sv]
// Front end: classifies characters, builds decimal literals, emits commands.
module pee_front
    import pee_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_code,
    input  logic [31:0] i_var_value,
    input  logic        i_end_of_expr,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    output logic        o_cmd_flag,
    input  logic        i_cmd_stall
);

    // A character may need up to three commands: flush literal, own op, end
    localparam logic [1:0] PH_LIT = 2'd0;
    localparam logic [1:0] PH_OP  = 2'd1;
    localparam logic [1:0] PH_END = 2'd2;

    logic        r_busy;
    logic [1:0]  r_phase;
    logic [7:0]  r_char;
    logic [31:0] r_var;
    logic        r_last;
    logic [31:0] r_acc;
    logic        r_in_num;
    logic [31:0] mul10;
    logic        is_digit;
    logic        is_letter;
    logic        is_oper;
    logic [2:0]  oper_code;
    logic        cmd_take;

    assign o_stall = r_busy;

    always_comb begin
        is_digit  = (r_char >= CH_ZERO) && (r_char <= CH_NINE);
        is_letter = ((r_char >= 8'h41) && (r_char <= 8'h5A)) ||
                    ((r_char >= 8'h61) && (r_char <= 8'h7A));
        is_oper   = 1'b1;
        oper_code = OP_NONE;
        case (r_char)
            CH_PLUS:  oper_code = OP_ADD;
            CH_MINUS: oper_code = OP_SUB;
            CH_STAR:  oper_code = OP_MUL;
            CH_SLASH: oper_code = OP_DIV;
            CH_CARET: oper_code = OP_POW;
            default:  is_oper = 1'b0;
        endcase
        mul10 = r_acc * DEC_BASE;
    end

    // Pick the command for the current phase
    always_comb begin
        o_cmd_valid = 1'b0;
        o_cmd_flag  = 1'b0;
        o_cmd.op    = OP_NONE;
        o_cmd.value = r_var;
        if (r_busy) begin
            unique case (r_phase)
                PH_LIT: begin
                    o_cmd_valid = r_in_num && !is_digit;
                    o_cmd.op    = OP_PUSH;
                    o_cmd.value = r_acc;
                end
                PH_OP: begin
                    o_cmd_valid = is_letter || is_oper;
                    o_cmd.op    = is_letter ? OP_PUSH : oper_code;
                end
                PH_END: begin
                    // End command carries a pending literal and its flag
                    o_cmd_valid = 1'b1;
                    o_cmd.op    = OP_END;
                    o_cmd.value = r_acc;
                    o_cmd_flag  = r_in_num;
                end
                default: o_cmd_valid = 1'b0;
            endcase
        end
    end

    assign cmd_take = !o_cmd_valid || !i_cmd_stall;

    // Sequence phases, fold digits into the literal
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_phase  <= PH_LIT;
            r_acc    <= '0;
            r_in_num <= 1'b0;
        end else if (!r_busy) begin
            if (i_valid) begin
                r_busy  <= 1'b1;
                r_phase <= PH_LIT;
                r_char  <= i_char_code;
                r_var   <= i_var_value;
                r_last  <= i_end_of_expr;
            end
        end else if (cmd_take) begin
            unique case (r_phase)
                PH_LIT: begin
                    if (is_digit) begin
                        r_acc    <= mul10 + {24'd0, r_char - CH_ZERO};
                        r_in_num <= 1'b1;
                    end else if (r_in_num) begin
                        r_acc    <= '0;
                        r_in_num <= 1'b0;
                    end
                    r_phase <= PH_OP;
                end
                PH_OP: begin
                    if (r_last) begin
                        r_phase <= PH_END;
                    end else begin
                        r_busy <= 1'b0;
                    end
                end
                PH_END: begin
                    // Drop the literal, it now travels with the end command
                    r_acc    <= '0;
                    r_in_num <= 1'b0;
                    r_busy   <= 1'b0;
                end
                default: r_busy <= 1'b0;
            endcase
        end
    end

endmodule

[rtl/pee_queue.sv]
// Short command queue between front end and execute unit.
module pee_queue
    import pee_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_cmd i_cmd,
    input  logic i_flag,
    output logic o_valid,
    input  logic i_stall,
    output t_cmd o_cmd,
    output logic o_flag
);

    localparam int DEPTH = 4;

    t_cmd       r_mem [DEPTH];
    logic       r_flg [DEPTH];
    logic [1:0] r_wp;
    logic [1:0] r_rp;
    logic [2:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_stall = (r_cnt == 3'(DEPTH));
    assign o_valid = (r_cnt != 3'd0);
    assign o_cmd   = r_mem[r_rp];
    assign o_flag  = r_flg[r_rp];
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_mem[r_wp] <= i_cmd;
                r_flg[r_wp] <= i_flag;
                r_wp        <= r_wp + 2'd1;
            end
            if (pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + {2'd0, push} - {2'd0, pop};
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(DEPTH)) else $error("queue count out of range");

endmodule

[rtl/pee_exec.sv]
// Execute unit: operand stack, arithmetic, iterative divide and power.
module pee_exec
    import pee_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    output logic        o_cmd_stall,
    input  t_cmd        i_cmd,
    input  logic        i_lit_pend,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_result_value,
    output logic [1:0]  o_status
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD1  = 4'd1;
    localparam logic [3:0] S_RD2  = 4'd2;
    localparam logic [3:0] S_CALC = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_POW  = 4'd5;
    localparam logic [3:0] S_PWSQ = 4'd6;
    localparam logic [3:0] S_WB   = 4'd7;
    localparam logic [3:0] S_EPSH = 4'd8;
    localparam logic [3:0] S_EPOP = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [31:0]   r_stack [STACK_DEPTH];
    logic [31:0]   r_rdata;
    logic [3:0]    r_state;
    logic [CW-1:0] r_cnt;
    logic [1:0]    r_err;
    logic [2:0]    r_op;
    logic [31:0]   r_lhs;
    logic [31:0]   r_rhs;
    logic [31:0]   r_res;
    logic [31:0]   r_rem;
    logic [31:0]   r_quo;
    logic [5:0]    r_it;
    logic          r_neg;
    logic          r_ovalid;
    logic [31:0]   r_oval;
    logic [1:0]    r_ostat;
    logic [AW-1:0] rd_addr;
    logic          rd_pop;
    logic          rd_en;
    logic          wr_en;
    logic [32:0]   trial;
    logic [31:0]   ma;
    logic [31:0]   mb;
    logic [31:0]   mul_out;

    assign o_cmd_stall   = (r_state != S_IDLE);
    assign o_valid        = r_ovalid;
    assign o_result_value = r_oval;
    assign o_status       = r_ostat;

    assign ma    = r_lhs[31] ? (32'd0 - r_lhs) : r_lhs;
    assign mb    = r_rhs[31] ? (32'd0 - r_rhs) : r_rhs;
    assign trial = {r_rem, r_quo[31]} - {1'b0, mb};
    assign mul_out = ((r_state == S_POW) ? r_res : r_lhs) * r_lhs;

    // Stack read port, registered; an empty pop reads as zero
    always_comb begin
        rd_pop  = (r_state == S_RD1 || r_state == S_RD2 || r_state == S_EPOP);
        rd_en   = 1'b0;
        rd_addr = '0;
        if (rd_pop && r_cnt != '0) begin
            rd_en   = 1'b1;
            rd_addr = AW'(r_cnt - CW'(1));
        end
        wr_en = (r_state == S_WB || r_state == S_EPSH) && r_cnt != FULL;
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_stack[rd_addr];
        end else if (rd_pop) begin
            r_rdata <= '0;
        end
        if (wr_en) begin
            r_stack[AW'(r_cnt)] <= r_res;
        end
    end

    // Sequence one command at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_err    <= ST_OK;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_op <= i_cmd.op;
                        if (i_cmd.op == OP_PUSH) begin
                            r_res   <= i_cmd.value;
                            r_state <= S_WB;
                        end else if (i_cmd.op == OP_END) begin
                            r_res   <= i_cmd.value;
                            r_state <= i_lit_pend ? S_EPSH : S_EPOP;
                        end else if (i_cmd.op != OP_NONE) begin
                            r_state <= S_RD1;
                        end
                    end
                end
                S_RD1: begin
                    if (r_cnt != '0) r_cnt <= r_cnt - CW'(1);
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_rhs <= r_rdata;
                    if (r_cnt != '0) r_cnt <= r_cnt - CW'(1);
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    r_lhs <= r_rdata;
                    case (r_op)
                        OP_ADD: begin
                            r_res   <= r_rdata + r_rhs;
                            r_state <= S_WB;
                        end
                        OP_SUB: begin
                            r_res   <= r_rdata - r_rhs;
                            r_state <= S_WB;
                        end
                        OP_MUL: begin
                            r_res   <= r_rdata * r_rhs;
                            r_state <= S_WB;
                        end
                        OP_DIV: begin
                            if (r_rhs == '0) begin
                                r_res   <= '0;
                                r_state <= S_WB;
                                if (r_err == ST_OK) r_err <= ST_DIV_ZERO;
                            end else begin
                                r_state <= S_DIV;
                                r_rem   <= '0;
                                r_it    <= 6'd0;
                                r_neg   <= r_rdata[31] ^ r_rhs[31];
                            end
                        end
                        default: begin
                            if (!r_rhs[31]) begin
                                r_res   <= 32'd1;
                                r_state <= S_POW;
                            end else begin
                                r_state <= S_WB;
                                if (r_rdata == 32'd1) r_res <= 32'd1;
                                else if (r_rdata == 32'hFFFF_FFFF)
                                    r_res <= r_rhs[0] ? 32'hFFFF_FFFF : 32'd1;
                                else r_res <= '0;
                            end
                        end
                    endcase
                end
                S_DIV: begin
                    // One quotient bit per cycle, restoring
                    if (r_it == 6'd0) begin
                        r_quo <= ma;
                        r_it  <= 6'd1;
                    end else begin
                        if (!trial[32]) begin
                            r_rem <= trial[31:0];
                            r_quo <= {r_quo[30:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[30:0], r_quo[31]};
                            r_quo <= {r_quo[30:0], 1'b0};
                        end
                        if (r_it == 6'd32) begin
                            r_state <= S_WB;
                            r_res <= (!trial[32]) ?
                                (r_neg ? 32'd0 - {r_quo[30:0], 1'b1}
                                       : {r_quo[30:0], 1'b1}) :
                                (r_neg ? 32'd0 - {r_quo[30:0], 1'b0}
                                       : {r_quo[30:0], 1'b0});
                        end
                        r_it <= r_it + 6'd1;
                    end
                end
                S_POW: begin
                    // Square and multiply: S_POW multiplies in the low exponent bit, S_PWSQ squares the base
                    if (r_rhs == '0) begin
                        r_state <= S_WB;
                    end else begin
                        if (r_rhs[0]) r_res <= mul_out;
                        r_rhs   <= {1'b0, r_rhs[31:1]};
                        r_state <= S_PWSQ;
                    end
                end
                S_PWSQ: begin
                    r_lhs   <= mul_out;
                    r_state <= S_POW;
                end
                S_WB: begin
                    if (r_cnt != FULL) r_cnt <= r_cnt + CW'(1);
                    else if (r_err == ST_OK) r_err <= ST_OVERFLOW;
                    r_it    <= '0;
                    r_state <= S_IDLE;
                end
                S_EPSH: begin
                    // Push the literal that ended the expression
                    if (r_cnt != FULL) r_cnt <= r_cnt + CW'(1);
                    else if (r_err == ST_OK) r_err <= ST_OVERFLOW;
                    r_state <= S_EPOP;
                end
                S_EPOP: begin
                    if (r_cnt != '0) r_cnt <= r_cnt - CW'(1);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid <= 1'b1;
                        r_oval   <= r_rdata;
                        r_ostat  <= (r_err == ST_OK && r_cnt != '0) ?
                                    ST_LEFTOVER : r_err;
                        r_cnt    <= '0;
                        r_err    <= ST_OK;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL) else $error("stack count beyond depth");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && (!r_ovalid || !i_stall)) |=> r_ovalid)
        else $error("result not presented");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WB) |=> (r_state == S_IDLE))
        else $error("writeback did not retire");

endmodule

[rtl/postfix_expression_evaluator_core.sv]
// Postfix expression evaluator: one character per input request, evaluated on a
// 32-bit operand stack of STACK_DEPTH entries. Digit runs build decimal literals,
// letters push i_var_value, and + - * / ^ pop two operands (an empty stack gives 0)
// and push the wrapped result. A result request with the top of stack and a status
// (ok, divide by zero, leftover operands, stack overflow; first error kept) is
// produced only for a character marked as end of expression. The front end stalls
// while it works through a character's phases and while the four-entry command queue
// is full. In the execute unit a push goes through S_WB; add, subtract and multiply
// through S_RD1, S_RD2, S_CALC and S_WB; divide loops in S_DIV (one quotient bit per
// cycle) and power alternates S_POW and S_PWSQ (square and multiply). Closing an
// expression: S_EPSH if a literal is pending, S_EPOP, S_OUT (holds while stalled).
module postfix_expression_evaluator_core
    import pee_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_code,
    input  logic signed [31:0] i_var_value,
    input  logic        i_end_of_expr,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [31:0] o_result_value,
    output logic [1:0]  o_status
);

    logic        f_valid;
    t_cmd        f_cmd;
    logic        f_flag;
    logic        q_stall;
    logic        q_valid;
    t_cmd        q_cmd;
    logic        q_flag;
    logic        x_stall;
    logic [31:0] x_res;

    pee_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_char_code, .i_var_value(i_var_value), .i_end_of_expr,
        .o_cmd_valid(f_valid), .o_cmd(f_cmd), .o_cmd_flag(f_flag),
        .i_cmd_stall(q_stall)
    );

    pee_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_stall(q_stall), .i_cmd(f_cmd),
        .i_flag(f_flag),
        .o_valid(q_valid), .i_stall(x_stall), .o_cmd(q_cmd), .o_flag(q_flag)
    );

    pee_exec #(.STACK_DEPTH(STACK_DEPTH)) u_exec (
        .i_clk, .i_rst_n,
        .i_cmd_valid(q_valid), .o_cmd_stall(x_stall), .i_cmd(q_cmd),
        .i_lit_pend(q_flag),
        .o_valid, .i_stall, .o_result_value(x_res), .o_status
    );

    assign o_result_value = x_res;

endmodule
